// ===== rtl/core/nearest_neighbor_image_scaler_macros.svh =====
// assertion helpers for the image scaler, empty when synthesizing
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NNS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define NNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NNS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define NNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/nns_pkg.sv =====
`timescale 1ns / 1ps
package nns_pkg;

  localparam int CHAN_BITS      = 8;
  localparam int DIM_BITS       = 9;
  localparam int POS_BITS       = 8;
  localparam int LOAD_ADDR_BITS = 16;
  localparam int PROD_BITS      = 2 * DIM_BITS;
  localparam int NUM_BITS       = PROD_BITS + 2;
  localparam int EA_BITS        = 2 * DIM_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_ROUND_HALF
  } nns_reg_t;

  typedef struct packed {
    logic                 kind;
    logic [CHAN_BITS-1:0] in_red;
    logic [CHAN_BITS-1:0] in_green;
    logic [CHAN_BITS-1:0] in_blue;
  } nns_req_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] out_red;
    logic [CHAN_BITS-1:0] out_green;
    logic [CHAN_BITS-1:0] out_blue;
    logic [POS_BITS-1:0]  dest_col;
    logic [POS_BITS-1:0]  dest_row;
    logic                 last;
  } nns_pix_t;

  // effective sizes, already clamped to 1..max
  typedef struct packed {
    logic [DIM_BITS-1:0] src_width;
    logic [DIM_BITS-1:0] src_height;
    logic [DIM_BITS-1:0] dst_width;
    logic [DIM_BITS-1:0] dst_height;
    logic                round_half;
  } nns_cfg_t;

  // classified item as it travels from front to back
  typedef struct packed {
    logic                      kind;
    logic [CHAN_BITS-1:0]      red;
    logic [CHAN_BITS-1:0]      green;
    logic [CHAN_BITS-1:0]      blue;
    logic [LOAD_ADDR_BITS-1:0] load_addr;
    logic [DIM_BITS-1:0]       col;
    logic [DIM_BITS-1:0]       row;
    logic                      last;
  } nns_op_t;

  typedef struct packed {
    logic    push;
    nns_op_t op;
  } nns_qpush_t;

  typedef struct packed {
    logic    valid;
    nns_op_t op;
  } nns_qhead_t;

endpackage

// ===== rtl/core/nns_ram.sv =====
`timescale 1ns / 1ps
module nns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/nns_front.sv =====
`timescale 1ns / 1ps
module nns_front (
  input  logic                clk,
  input  logic                rst,
  input  nns_pkg::nns_cfg_t   cfg,
  input  logic                req_valid,
  output logic                req_stall,
  input  nns_pkg::nns_req_t   req,
  input  logic                q_full,
  output nns_pkg::nns_qpush_t qpush
);
  import nns_pkg::*;

  logic [LOAD_ADDR_BITS-1:0] load_addr;
  logic [DIM_BITS-1:0]       emit_col;
  logic [DIM_BITS-1:0]       emit_row;

  logic [EA_BITS-1:0]        frame_size;
  logic [LOAD_ADDR_BITS:0]   load_inc;
  logic [DIM_BITS:0]         col_inc;
  logic [DIM_BITS:0]         row_inc;
  logic                      end_col;
  logic                      end_row;
  logic                      accept;

  assign req_stall  = q_full;
  assign accept     = req_valid && !q_full;

  assign frame_size = EA_BITS'(cfg.src_width) * EA_BITS'(cfg.src_height);
  assign load_inc   = {1'b0, load_addr} + 1'b1;
  assign col_inc    = {1'b0, emit_col} + 1'b1;
  assign row_inc    = {1'b0, emit_row} + 1'b1;
  assign end_col    = col_inc >= {1'b0, cfg.dst_width};
  assign end_row    = row_inc >= {1'b0, cfg.dst_height};

  always_comb begin
    qpush.push         = accept;
    qpush.op.kind      = req.kind;
    qpush.op.red       = req.in_red;
    qpush.op.green     = req.in_green;
    qpush.op.blue      = req.in_blue;
    qpush.op.load_addr = load_addr;
    qpush.op.col       = emit_col;
    qpush.op.row       = emit_row;
    qpush.op.last      = end_col && end_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_addr <= '0;
      emit_col  <= '0;
      emit_row  <= '0;
    end else if (accept) begin
      if (req.kind == KIND_LOAD) begin
        // wrap once the whole source frame is in
        if (EA_BITS'(load_inc) >= frame_size) begin
          load_addr <= '0;
        end else begin
          load_addr <= load_inc[LOAD_ADDR_BITS-1:0];
        end
      end else begin
        if (end_col) begin
          emit_col <= '0;
          emit_row <= end_row ? '0 : row_inc[DIM_BITS-1:0];
        end else begin
          emit_col <= col_inc[DIM_BITS-1:0];
        end
      end
    end
  end

endmodule

// ===== rtl/core/nns_queue.sv =====
`timescale 1ns / 1ps
module nns_queue #(
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  nns_pkg::nns_qpush_t qpush,
  output logic                full,
  input  logic                pop,
  output nns_pkg::nns_qhead_t head
);
  import nns_pkg::*;

  nns_op_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == CW'(DEPTH);
  assign head.valid = count != '0;
  assign head.op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (qpush.push) begin
      slots[wr_ptr] <= qpush.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qpush.push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (qpush.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !qpush.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/nns_back.sv =====
`timescale 1ns / 1ps
module nns_back #(
  parameter int CHANNEL_BITS = 8,
  parameter int RAM_DEPTH = 65536,
  localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1,
  localparam int CNT_BITS = $clog2(nns_pkg::NUM_BITS)
) (
  input  logic                clk,
  input  logic                rst,
  input  nns_pkg::nns_cfg_t   cfg,
  input  nns_pkg::nns_qhead_t head,
  output logic                pop,
  output logic                busy,
  output logic                pix_valid,
  input  logic                pix_stall,
  output nns_pkg::nns_pix_t   pix
);
  import nns_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_CLAMP,
    B_ADDR,
    B_READ,
    B_DONE
  } state_t;

  state_t                              state;
  logic [CNT_BITS-1:0]                 cnt;
  logic [1:0][PROD_BITS-1:0]           prod;
  logic [1:0][NUM_BITS-1:0]            num;
  logic [1:0][NUM_BITS-1:0]            quo;
  logic [1:0][DIM_BITS:0]              rem;
  logic [1:0][DIM_BITS-1:0]            idx;
  logic [AW-1:0]                       rd_addr;
  logic [POS_BITS-1:0]                 dest_col;
  logic [POS_BITS-1:0]                 dest_row;
  logic                                dest_last;

  // lane 0 maps the column, lane 1 the row
  logic [1:0][DIM_BITS-1:0]            lane_s;
  logic [1:0][DIM_BITS-1:0]            lane_t;
  logic [1:0][DIM_BITS:0]              den;
  logic [1:0][DIM_BITS+1:0]            trial;
  logic [1:0][DIM_BITS+1:0]            diff;
  logic [1:0]                          ge;
  logic [1:0][DIM_BITS-1:0]            s_m1;
  logic [1:0][DIM_BITS-1:0]            idx_c;
  logic [EA_BITS-1:0]                  ea;

  logic                                wr_en;
  logic [3*CHANNEL_BITS-1:0]           wr_data;
  logic                                rd_en;
  logic [3*CHANNEL_BITS-1:0]           rd_data;
  logic                                out_free;

  assign lane_s[0] = cfg.src_width;
  assign lane_s[1] = cfg.src_height;
  assign lane_t[0] = cfg.dst_width;
  assign lane_t[1] = cfg.dst_height;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      den[l]   = {lane_t[l], 1'b0};
      trial[l] = {rem[l], num[l][NUM_BITS-1]};
      diff[l]  = trial[l] - {1'b0, den[l]};
      ge[l]    = trial[l] >= {1'b0, den[l]};
      s_m1[l]  = lane_s[l] - 1'b1;
      idx_c[l] = (quo[l] > NUM_BITS'(s_m1[l])) ? s_m1[l] : quo[l][DIM_BITS-1:0];
    end
  end

  assign ea = EA_BITS'(idx[1]) * EA_BITS'(cfg.src_width) + EA_BITS'(idx[0]);

  assign pop      = (state == B_IDLE) && head.valid;
  assign busy     = state != B_IDLE;
  assign out_free = !pix_valid || !pix_stall;

  assign wr_en   = pop && (head.op.kind == KIND_LOAD)
                   && (int'(head.op.load_addr) < RAM_DEPTH);
  assign wr_data = {CHANNEL_BITS'(head.op.red), CHANNEL_BITS'(head.op.green),
                    CHANNEL_BITS'(head.op.blue)};
  assign rd_en   = state == B_READ;

  nns_ram #(
    .WIDTH (3 * CHANNEL_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(head.op.load_addr)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      pix_valid <= 1'b0;
    end else begin
      // a pixel taken this cycle clears valid unless the next one replaces it
      if (pix_valid && !pix_stall && state != B_DONE) begin
        pix_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop && head.op.kind == KIND_EMIT) begin
            prod[0]   <= PROD_BITS'(head.op.col) * PROD_BITS'(cfg.src_width);
            prod[1]   <= PROD_BITS'(head.op.row) * PROD_BITS'(cfg.src_height);
            dest_col  <= head.op.col[POS_BITS-1:0];
            dest_row  <= head.op.row[POS_BITS-1:0];
            dest_last <= head.op.last;
            state     <= B_PREP;
          end
        end
        B_PREP: begin
          for (int l = 0; l < 2; l++) begin
            num[l] <= NUM_BITS'({prod[l], 1'b0})
                      + (cfg.round_half ? NUM_BITS'(lane_t[l]) : '0);
            rem[l] <= '0;
            quo[l] <= '0;
          end
          cnt   <= CNT_BITS'(NUM_BITS - 1);
          state <= B_DIV;
        end
        B_DIV: begin
          // one restoring step per lane and cycle
          for (int l = 0; l < 2; l++) begin
            num[l] <= {num[l][NUM_BITS-2:0], 1'b0};
            quo[l] <= {quo[l][NUM_BITS-2:0], ge[l]};
            rem[l] <= ge[l] ? diff[l][DIM_BITS:0] : trial[l][DIM_BITS:0];
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= B_CLAMP;
          end
        end
        B_CLAMP: begin
          idx   <= idx_c;
          state <= B_ADDR;
        end
        B_ADDR: begin
          if (int'(ea) > RAM_DEPTH - 1) begin
            rd_addr <= AW'(RAM_DEPTH - 1);
          end else begin
            rd_addr <= AW'(ea);
          end
          state <= B_READ;
        end
        B_READ: begin
          state <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            pix_valid     <= 1'b1;
            pix.out_red   <= CHAN_BITS'(rd_data[3*CHANNEL_BITS-1 -: CHANNEL_BITS]);
            pix.out_green <= CHAN_BITS'(rd_data[2*CHANNEL_BITS-1 -: CHANNEL_BITS]);
            pix.out_blue  <= CHAN_BITS'(rd_data[CHANNEL_BITS-1:0]);
            pix.dest_col  <= dest_col;
            pix.dest_row  <= dest_row;
            pix.last      <= dest_last;
            state         <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/nearest_neighbor_image_scaler.sv =====
// a load item is written to the frame store as the back end pops it from the queue;
// an emit item passes prep, divide, clamp, address, read and done, where it waits out a stall
// throughput: 1 load item per cycle while the back end is idle; an emit item holds the back
// end, with its 20-step bit-serial divider that maps column and row, until its pixel is out;
// a 4-entry queue sits in between. reset (rst, synchronous): sizes go to 256, round_half to 0,
// front and queue counters to zero; the frame store is not cleared and holds garbage until loaded
`timescale 1ns / 1ps
`include "nearest_neighbor_image_scaler_macros.svh"
module nearest_neighbor_image_scaler #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [nns_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [nns_pkg::DIM_BITS-1:0]         cfg_data,
  // request items: load a source pixel or emit the next destination pixel
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  nns_pkg::nns_req_t                    req,
  // destination pixels
  output logic                                 pix_valid,
  input  logic                                 pix_stall,
  output nns_pkg::nns_pix_t                    pix
);
  import nns_pkg::*;

  localparam int RAM_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // raw register values as written
  logic [DIM_BITS-1:0] src_width;
  logic [DIM_BITS-1:0] src_height;
  logic [DIM_BITS-1:0] dst_width;
  logic [DIM_BITS-1:0] dst_height;
  logic                round_half;

  nns_cfg_t   cfg;
  nns_qpush_t qpush;
  nns_qhead_t qhead;
  logic       q_full;
  logic       q_pop;
  logic       back_busy;

  // zero acts as one, anything past the store dimension acts as the maximum
  function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v,
                                                  input int max);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (int'(v) > max) begin
      r = DIM_BITS'(max);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    cfg.src_width  = eff_dim(src_width, MAX_WIDTH);
    cfg.src_height = eff_dim(src_height, MAX_HEIGHT);
    cfg.dst_width  = eff_dim(dst_width, MAX_WIDTH);
    cfg.dst_height = eff_dim(dst_height, MAX_HEIGHT);
    cfg.round_half = round_half;
  end

  // register file; the user must write only while the datapath is idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_BITS'(256);
      src_height <= DIM_BITS'(256);
      dst_width  <= DIM_BITS'(256);
      dst_height <= DIM_BITS'(256);
      round_half <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_DST_WIDTH:  dst_width  <= cfg_data;
        REG_DST_HEIGHT: dst_height <= cfg_data;
        REG_ROUND_HALF: round_half <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: take items, hand out load addresses and destination positions
  nns_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .qpush     (qpush)
  );

  // decoupling queue between classification and execution
  nns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .full  (q_full),
    .pop   (q_pop),
    .head  (qhead)
  );

  // back: frame store writes, index mapping, store reads, output register
  nns_back #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .RAM_DEPTH    (RAM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (qhead),
    .pop       (q_pop),
    .busy      (back_busy),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

  // queue never overfills and never underflows
  `NNS_ASSERT_IMPL(a_no_push_full, clk, rst, q_full, !qpush.push, "push into full queue")
  `NNS_ASSERT_IMPL(a_pop_has_item, clk, rst, q_pop, qhead.valid, "pop from empty queue")
  // an emit item occupies the back end, which then takes nothing new
  `NNS_ASSERT_NEXT(a_emit_busy, clk, rst, q_pop && qhead.op.kind == KIND_EMIT, back_busy, "emit did not start")
  `NNS_ASSERT_IMPL(a_busy_no_pop, clk, rst, back_busy, !q_pop, "pop while back end busy")

endmodule
